// File: rtl/two_digit_matrix_renderer_assert.svh
// Assertion macros for the two-digit matrix renderer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef TWO_DIGIT_MATRIX_RENDERER_ASSERT_SVH
`define TWO_DIGIT_MATRIX_RENDERER_ASSERT_SVH

// same-cycle implication, checks off while reset is asserted
`define TDMR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("tdmr assertion failed");

// next-cycle implication, checks off while reset is asserted
`define TDMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("tdmr assertion failed");

`endif

// File: rtl/tdmr_pkg.sv
// Shared types, constants and glyph font for the two-digit matrix renderer.
// No dependencies.
package tdmr_pkg;

  localparam int unsigned RowCntW   = 4;
  localparam logic [RowCntW-1:0] LastRowCnt = 4'd15;
  localparam logic [6:0]  ScoreMax  = 7'd99;

  typedef struct packed {
    logic       chain;
    logic       blank;
    logic [3:0] tens;
    logic [3:0] units;
  } tdmr_digits_t;

  localparam logic [7:0] GlyphRom [10][8] = '{
    '{8'h3C, 8'h66, 8'h6E, 8'h76, 8'h66, 8'h66, 8'h3C, 8'h00},
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00},
    '{8'h3C, 8'h66, 8'h06, 8'h0C, 8'h30, 8'h60, 8'h7E, 8'h00},
    '{8'h3C, 8'h66, 8'h06, 8'h1C, 8'h06, 8'h66, 8'h3C, 8'h00},
    '{8'h0C, 8'h1C, 8'h2C, 8'h4C, 8'h7E, 8'h0C, 8'h0C, 8'h00},
    '{8'h7E, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h66, 8'h3C, 8'h00},
    '{8'h3C, 8'h66, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h3C, 8'h00},
    '{8'h7E, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h30, 8'h30, 8'h00},
    '{8'h3C, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h3C, 8'h00},
    '{8'h3C, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h66, 8'h3C, 8'h00}
  };

  // bit j of row r = bit (7-r) of glyph row j
  function automatic logic [7:0] rotated_row(input logic [3:0] digit, input logic [2:0] row);
    logic [7:0] pat;
    logic [7:0] glyph;
    pat = '0;
    for (int j = 0; j < 8; j++) begin
      glyph  = (digit > 4'd9) ? 8'h00 : GlyphRom[digit][j];
      pat[j] = glyph[~row];
    end
    return pat;
  endfunction

endpackage

// File: rtl/tdmr_if.sv
// Valid/ready channel interfaces for score input and row-write output.
// No dependencies.
interface tdmr_in_if;
  logic               valid;
  logic               ready;
  logic               display_select;
  logic signed [10:0] score;

  modport source (output valid, output display_select, output score, input ready);
  modport sink   (input valid, input display_select, input score, output ready);
endinterface

interface tdmr_out_if;
  logic       valid;
  logic       ready;
  logic       chain_id;
  logic       module_index;
  logic [2:0] row_index;
  logic [7:0] row_pattern;
  logic       final_row;

  modport source (output valid, output chain_id, output module_index, output row_index,
                  output row_pattern, output final_row, input ready);
  modport sink   (input valid, input chain_id, input module_index, input row_index,
                  input row_pattern, input final_row, output ready);
endinterface

// File: rtl/two_digit_matrix_renderer.sv
// Two-digit renderer: each score transaction yields sixteen row writes, one per
// cycle while the output is not stalled by ready; the rows are carried by the
// single output register. An item passes through the pending register, the item
// register and the output register on its way to the first row. One further item is buffered
// while the current one is still being sent, so items follow without gaps.
// Depends on tdmr_pkg, tdmr_if, tdmr_digit_split and tdmr_row_gen.
module two_digit_matrix_renderer import tdmr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdmr_in_if.sink    in_i,
  tdmr_out_if.source out_o
);

  logic         pend_valid;
  logic         take;
  tdmr_digits_t pend;

  tdmr_digit_split u_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .take_i       (take),
    .pend_valid_o (pend_valid),
    .pend_o       (pend)
  );

  tdmr_row_gen u_rows (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_valid_i (pend_valid),
    .pend_i       (pend),
    .take_o       (take),
    .out_o        (out_o)
  );

endmodule

// File: rtl/tdmr_digit_split.sv
// Input stage: clamps the score, splits tens/units and holds one pending item.
// Depends on tdmr_pkg and tdmr_in_if.
module tdmr_digit_split import tdmr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  tdmr_in_if.sink      in_i,
  input  logic         take_i,
  output logic         pend_valid_o,
  output tdmr_digits_t pend_o
);

  logic         pend_valid_q, pend_valid_d;
  tdmr_digits_t pend_q, pend_d;
  logic         accept;
  logic [6:0]   val;
  logic [14:0]  prod;
  logic [3:0]   tens;
  logic [6:0]   tens_x10;

  assign in_i.ready = !pend_valid_q || take_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    priority if (in_i.score[10]) begin
      val = 7'd0;
    end else if (in_i.score[9:0] > 10'(ScoreMax)) begin
      val = ScoreMax;
    end else begin
      val = in_i.score[6:0];
    end
    // val / 10 by reciprocal, exact for 0..99
    prod     = 15'(val) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    pend_d.chain = in_i.display_select;
    pend_d.blank = (tens == 4'd0);
    pend_d.tens  = tens;
    pend_d.units = 4'(val - tens_x10);
  end

  always_comb begin
    priority if (accept) begin
      pend_valid_d = 1'b1;
    end else if (take_i) begin
      pend_valid_d = 1'b0;
    end else begin
      pend_valid_d = pend_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

  assign pend_valid_o = pend_valid_q;
  assign pend_o       = pend_q;

endmodule

// File: rtl/tdmr_row_gen.sv
// Row sequencer: walks sixteen row writes per item into the output register.
// Depends on tdmr_pkg and tdmr_out_if.
module tdmr_row_gen import tdmr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         pend_valid_i,
  input  tdmr_digits_t pend_i,
  output logic         take_o,
  tdmr_out_if.source   out_o
);

  logic               busy_q, busy_d;
  logic [RowCntW-1:0] cnt_q, cnt_d;
  tdmr_digits_t       item_q;
  logic               out_valid_q, out_valid_d;
  logic               chain_q, module_q, final_q;
  logic [2:0]         row_q;
  logic [7:0]         pat_q, pat_d;
  logic               step, emit, last;

  assign step   = !out_valid_q || out_o.ready;
  assign emit   = busy_q && step;
  assign last   = (cnt_q == LastRowCnt);
  assign take_o = pend_valid_i && (!busy_q || (emit && last));

  always_comb begin
    priority if (take_o) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (emit) begin
      busy_d = !last;
      cnt_d  = cnt_q + 1'b1;
    end else begin
      busy_d = busy_q;
      cnt_d  = cnt_q;
    end
    out_valid_d = emit || (out_valid_q && !out_o.ready);
    if (cnt_q[3]) begin
      pat_d = rotated_row(item_q.units, cnt_q[2:0]);
    end else begin
      pat_d = item_q.blank ? 8'h00 : rotated_row(item_q.tens, cnt_q[2:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      item_q <= pend_i;
    end
    if (emit) begin
      chain_q  <= item_q.chain;
      module_q <= cnt_q[3];
      row_q    <= cnt_q[2:0];
      pat_q    <= pat_d;
      final_q  <= last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.chain_id     = chain_q;
  assign out_o.module_index = module_q;
  assign out_o.row_index    = row_q;
  assign out_o.row_pattern  = pat_q;
  assign out_o.final_row    = final_q;

endmodule

// File: rtl/tdmr_checker.sv
// Port-level checker for the row-write output of the renderer, bound to the top.
// Depends on two_digit_matrix_renderer_assert.svh.
`include "two_digit_matrix_renderer_assert.svh"

module tdmr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       chain_id_i,
  input logic       module_index_i,
  input logic [2:0] row_index_i,
  input logic [7:0] row_pattern_i,
  input logic       final_row_i
);

  logic [3:0] slot;
  logic [4:0] key;
  logic [4:0] key_nxt;
  logic       final_exp;
  logic       edge_ok;
  logic       mid_xfer;
  logic       stall;

  assign slot      = {module_index_i, row_index_i};
  assign key       = {chain_id_i, slot};
  assign key_nxt   = {chain_id_i, slot + 4'd1};
  assign final_exp = (slot == 4'hF);
  // glyph rows never use their top bit and the last glyph row is blank, so row 0 and column 7 stay dark
  assign edge_ok   = !row_pattern_i[7] && ((row_index_i != 3'd0) || (row_pattern_i == 8'h00));
  assign mid_xfer  = out_valid_i && out_ready_i && !final_row_i;
  assign stall     = out_valid_i && !out_ready_i;

  `TDMR_ASSERT_IMPL(a_final_pos, clk_i, rst_ni, out_valid_i, final_row_i == final_exp)
  `TDMR_ASSERT_IMPL(a_blank_edges, clk_i, rst_ni, out_valid_i, edge_ok)
  `TDMR_ASSERT_NEXT(a_row_follow, clk_i, rst_ni, mid_xfer, out_valid_i && (key == $past(key_nxt)))
  `TDMR_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall, out_valid_i && $stable(row_pattern_i))

endmodule

bind two_digit_matrix_renderer tdmr_checker u_tdmr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .chain_id_i     (out_o.chain_id),
  .module_index_i (out_o.module_index),
  .row_index_i    (out_o.row_index),
  .row_pattern_i  (out_o.row_pattern),
  .final_row_i    (out_o.final_row)
);

// File: test/testbench.sv
// Testbench for two_digit_matrix_renderer: score transactions in, sixteen rotated
// glyph row writes out, checked in order against an in-bench font renderer.
// Depends on tdmr_pkg, tdmr_if and the renderer RTL.
`timescale 1ns / 100ps

module testbench;
  import tdmr_pkg::*;

  localparam int LongHold = 200;
  localparam int MaxReports = 10;

  // private copy of the digit font, rows top to bottom
  localparam logic [7:0] DigitFont [10][8] = '{
    '{8'h3C, 8'h66, 8'h6E, 8'h76, 8'h66, 8'h66, 8'h3C, 8'h00},
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00},
    '{8'h3C, 8'h66, 8'h06, 8'h0C, 8'h30, 8'h60, 8'h7E, 8'h00},
    '{8'h3C, 8'h66, 8'h06, 8'h1C, 8'h06, 8'h66, 8'h3C, 8'h00},
    '{8'h0C, 8'h1C, 8'h2C, 8'h4C, 8'h7E, 8'h0C, 8'h0C, 8'h00},
    '{8'h7E, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h66, 8'h3C, 8'h00},
    '{8'h3C, 8'h66, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h3C, 8'h00},
    '{8'h7E, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h30, 8'h30, 8'h00},
    '{8'h3C, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h3C, 8'h00},
    '{8'h3C, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h66, 8'h3C, 8'h00}
  };

  typedef struct packed {
    logic               sel;
    logic signed [10:0] score;
  } score_item_t;

  typedef struct packed {
    logic       chain;
    logic       module_idx;
    logic [2:0] row;
    logic [7:0] pattern;
    logic       last;
  } row_write_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tdmr_in_if  in_ch ();
  tdmr_out_if out_ch ();

  two_digit_matrix_renderer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  score_item_t pending_scores[$];
  row_write_t  expected_rows[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int scores_taken;
  int rows_checked;
  int n_negative;
  int n_over;
  int n_blank_tens;
  logic hold_req;
  logic hold_ack;
  int   hold_left;

  // expected sixteen row writes for one score transaction
  task automatic render_score(input logic sel, input logic signed [10:0] score);
    int         val;
    int         digit;
    logic [7:0] pat;
    row_write_t w;
    if (score < 0) begin
      val = 0;
      n_negative++;
    end else if (score > 99) begin
      val = 99;
      n_over++;
    end else begin
      val = int'(score);
    end
    if (val < 10) n_blank_tens++;
    for (int m = 0; m < 2; m++) begin
      digit = (m == 0) ? val / 10 : val % 10;
      for (int r = 0; r < 8; r++) begin
        for (int j = 0; j < 8; j++) pat[j] = DigitFont[digit][j][7-r];
        if (m == 0 && val < 10) pat = 8'h00;
        w.chain      = sel;
        w.module_idx = m[0];
        w.row        = r[2:0];
        w.pattern    = pat;
        w.last       = (m == 1 && r == 7);
        expected_rows.push_back(w);
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    score_item_t nxt;
    if (!rst_ni) begin
      in_ch.valid          <= 1'b0;
      in_ch.display_select <= 1'b0;
      in_ch.score          <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_scores.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_scores.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.display_select <= nxt.sel;
        in_ch.score          <= nxt.score;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_ack  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_left <= LongHold;
      hold_ack  <= hold_req;
    end
  end

  // monitor: check row writes, then record new score transactions
  always @(posedge clk_i or negedge rst_ni) begin
    row_write_t got;
    row_write_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.chain      = out_ch.chain_id;
        got.module_idx = out_ch.module_index;
        got.row        = out_ch.row_index;
        got.pattern    = out_ch.row_pattern;
        got.last       = out_ch.final_row;
        rows_checked++;
        if (expected_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t: unexpected row write chain %0d module %0d row %0d pattern %02h last %0d",
                     $realtime, got.chain, got.module_idx, got.row, got.pattern, got.last);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("%0t: row write mismatch exp chain %0d module %0d row %0d pattern %02h last %0d",
                       $realtime, want.chain, want.module_idx, want.row, want.pattern, want.last);
              $display("    got chain %0d module %0d row %0d pattern %02h last %0d",
                       got.chain, got.module_idx, got.row, got.pattern, got.last);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        scores_taken++;
        render_score(in_ch.display_select, in_ch.score);
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic signed [10:0] random_score();
    case ($urandom_range(9))
      0, 1, 2, 3: return 11'($urandom_range(99));
      4, 5:       return 11'($urandom_range(1023, 100));
      6, 7:       return 11'(-int'($urandom_range(1024, 1)));
      default:    return 11'($urandom_range(2047));
    endcase
  endfunction

  task automatic add_score(input logic sel, input int score);
    score_item_t it;
    it.sel   = sel;
    it.score = 11'(score);
    pending_scores.push_back(it);
  endtask

  task automatic add_random(input int count);
    for (int i = 0; i < count; i++) add_score(1'($urandom_range(1)), int'(random_score()));
  endtask

  task automatic wait_drained();
    while (pending_scores.size() != 0 || in_ch.valid || expected_rows.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.display_select = 1'b0;
    in_ch.score          = '0;
    out_ch.ready         = 1'b0;
    rst_ni               = 1'b0;
    hold_req             = 1'b0;
    mismatches           = 0;
    scores_taken         = 0;
    rows_checked         = 0;
    n_negative           = 0;
    n_over               = 0;
    n_blank_tens         = 0;
    send_idle_pct        = 19;
    recv_idle_pct        = 53;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: range ends, clamping both ways, blank tens, every digit as units and every nonzero one as tens
    add_score(1'b0, 0);
    add_score(1'b1, 9);
    add_score(1'b0, 10);
    add_score(1'b1, 99);
    add_score(1'b0, 100);
    add_score(1'b1, 1023);
    add_score(1'b0, -1);
    add_score(1'b1, -1024);
    add_score(1'b0, 21);
    add_score(1'b1, 32);
    add_score(1'b0, 43);
    add_score(1'b1, 54);
    add_score(1'b0, 65);
    add_score(1'b1, 76);
    add_score(1'b0, 87);
    add_score(1'b1, 98);
    add_score(1'b0, 5);
    add_score(1'b1, 1);
    add_random(27);
    wait_drained();

    send_idle_pct = 53;
    recv_idle_pct = 19;
    add_random(25);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(30);
    while (pending_scores.size() > 25) @(negedge clk_i);
    hold_req = ~hold_req;
    wait_drained();

    repeat (20) @(negedge clk_i);
    if (expected_rows.size() != 0) mismatches++;

    $display("Covered %0d score transactions and %0d row writes on both chains.",
             scores_taken, rows_checked);
    $display("Clamped %0d negative and %0d over-range scores; %0d showed a blank tens module.",
             n_negative, n_over, n_blank_tens);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d row writes still expected.", expected_rows.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/tdmr_pkg.sv
rtl/tdmr_if.sv
rtl/tdmr_digit_split.sv
rtl/tdmr_row_gen.sv
rtl/two_digit_matrix_renderer.sv
rtl/tdmr_checker.sv
test/testbench.sv
